### design/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types, constants and the frame header parser for the device
// silence monitor.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int unsigned DEVICE_SLOTS_DEF = 64;
  localparam int unsigned RESULT_CAP       = 64;
  localparam int unsigned CAP_W            = $clog2(RESULT_CAP + 1);

  localparam logic [19:0] US_PER_S       = 20'd1000000;
  // one million = 15625 << 6; 15625 is divided by a reciprocal multiply
  localparam logic [13:0] US_ODD         = 14'd15625;
  localparam logic [30:0] US_RECIP       = 31'd1125899907;
  localparam int unsigned US_RECIP_SHIFT = 44;
  localparam logic [15:0] BROADCAST_ADDR = 16'hFFFF;
  localparam logic [15:0] THRESH_RESET   = 16'd120;
  localparam logic [15:0] THRESH_MIN     = 16'd5;
  localparam logic [7:0]  FRAMES_NEEDED_RESET = 8'd5;
  localparam logic [1:0]  MODE_NONE  = 2'd0;
  localparam logic [1:0]  MODE_SHORT = 2'd2;
  localparam logic [6:0]  MIN_LEN    = 7'd5;

  // configuration register indexes
  localparam logic CFG_THRESHOLD     = 1'b0;
  localparam logic CFG_FRAMES_NEEDED = 1'b1;

  // event kinds
  localparam logic KIND_RECOVER = 1'b0;
  localparam logic KIND_SILENT  = 1'b1;

  typedef struct packed {
    logic              used;
    logic              down;
    logic [7:0]        count;
    logic [15:0]       addr;
    logic [63:0]       seen;
    logic signed [7:0] rssi;
    logic [7:0]        lqi;
  } entry_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] addr;
  } src_t;

  // Locate the short source address in the MAC header.
  function automatic src_t parse_src(input logic [63:0] low, input logic [63:0] mid,
                                     input logic [7:0] top, input logic [6:0] len);
    logic [135:0] bytes;
    logic [15:0]  fcf;
    logic [1:0]   dmode;
    logic [1:0]   smode;
    logic [4:0]   pos;
    logic [135:0] shifted;
    src_t         r;
    bytes = {top, mid, low};
    fcf   = low[15:0];
    dmode = fcf[11:10];
    smode = fcf[15:14];
    pos   = 5'd3;
    if (dmode != MODE_NONE) pos = pos + ((dmode == MODE_SHORT) ? 5'd4 : 5'd10);
    if (!fcf[6]) pos = pos + 5'd2;
    shifted = bytes >> {pos, 3'b000};
    r.addr = shifted[15:0];
    r.ok   = (len >= MIN_LEN) && (smode == MODE_SHORT) &&
             ({2'b00, pos} + 7'd2 <= len) && (shifted[15:0] != BROADCAST_ADDR);
    return r;
  endfunction

endpackage

### design/dsm_ram.sv
// ----------------------------------------------------------------------------
// dsm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dsm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/dsm_div.sv
// ----------------------------------------------------------------------------
// dsm_div
// Divides a 64-bit value by one million: drops six low bits, then takes
// four 16-bit digits by 15625 with a reciprocal multiply and remainder step.
// ----------------------------------------------------------------------------
module dsm_div
  import dsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  output logic        done,
  output logic [63:0] quotient
);

  logic [2:0]  cnt;
  logic        phase;
  logic [13:0] rem;
  logic [63:0] work;
  logic [63:0] acc;
  logic [29:0] vin;
  logic [29:0] vreg;
  logic [15:0] qd;
  logic [60:0] prod;
  logic [29:0] back;
  logic [29:0] rem_full;

  // partial dividend: remainder so far plus the next digit, below 15625 * 2^16
  assign vin      = {rem, work[63:48]};
  assign prod     = {31'd0, vin} * {30'd0, US_RECIP};
  assign back     = {14'd0, qd} * {16'd0, US_ODD};
  assign rem_full = vreg - back;
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      phase <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt   <= 3'd4;
        phase <= 1'b0;
        rem   <= '0;
        work  <= {6'd0, dividend[63:6]};
        acc   <= '0;
      end else if (cnt != 3'd0) begin
        if (!phase) begin
          vreg  <= vin;
          qd    <= prod[US_RECIP_SHIFT +: 16];
          work  <= {work[47:0], 16'd0};
          phase <= 1'b1;
        end else begin
          rem   <= rem_full[13:0];
          acc   <= {acc[47:0], qd};
          cnt   <= cnt - 3'd1;
          phase <= 1'b0;
          if (cnt == 3'd1) done <= 1'b1;
        end
      end
    end
  end

endmodule

### design/device_silence_monitor_core.sv
// ----------------------------------------------------------------------------
// device_silence_monitor_core
// Table of radio devices keyed by short source address; reports devices
// that go silent and devices that come back.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: drive the item fields and pulse start; the transaction
//    is taken on a rising edge with start high and busy low. busy stays high
//    until every event of that item has been issued.
//  - Events leave on event_valid, one cycle each; the receiver cannot stall
//    them. last_of_run flags the final event of an item.
//  - Config: cfg_we/cfg_index/cfg_data write one register per cycle,
//    by the user only while busy is low (the block does not enforce
//    this). Threshold writes below 5 are dropped.
//  - Reset: a pass clears the slot RAM, busy high, taking config writes.
//  - Flow: one item first runs a stamp division (now / 1e6), then
//    walks slots, a read and a check each, through the single RAM
//    port. A frame stops at its matching slot and updates it; with no
//    match it takes the first free slot, if any. A tick walks every
//    slot, up to RESULT_CAP events, sending each silent device through
//    the shared divider, then flushes. Rejected frames finish at once.
// ----------------------------------------------------------------------------
module device_silence_monitor_core
  import dsm_pkg::*;
#(
  parameter int unsigned DEVICE_SLOTS = DEVICE_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [63:0]       now_us,
  input  logic [63:0]       header_low,
  input  logic [63:0]       header_mid,
  input  logic [7:0]        header_top,
  input  logic [6:0]        frame_len,
  input  logic signed [7:0] frame_rssi,
  input  logic [7:0]        frame_lqi,
  input  logic [7:0]        channel,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [15:0]       cfg_data,
  output logic              event_valid,
  output logic              event_kind,
  output logic [15:0]       device_addr,
  output logic signed [7:0] last_rssi,
  output logic [7:0]        last_lqi,
  output logic [7:0]        event_channel,
  output logic [44:0]       stamp_seconds,
  output logic [31:0]       silent_seconds,
  output logic              last_of_run
);

  localparam int unsigned IDX_W = (DEVICE_SLOTS > 1) ? $clog2(DEVICE_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEVICE_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_STAMP, ST_READ, ST_CHECK, ST_UPDATE, ST_GAPDIV, ST_FLUSH
  } state_t;

  state_t state;

  // config registers
  logic [15:0] threshold;
  logic [7:0]  frames_needed;

  // latched transaction
  logic              is_tick;
  logic [63:0]       now;
  logic [15:0]       src_addr;
  logic signed [7:0] rssi;
  logic [7:0]        lqi;
  logic [7:0]        chan;
  logic [44:0]       stamp;
  logic [35:0]       limit;

  // scan state
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] spare_idx;
  logic             spare_found;
  logic [IDX_W-1:0] slot_sel;
  logic             old_down;
  logic [7:0]       old_count;
  logic [CAP_W-1:0] ev_count;

  // held silence event
  logic              pend_valid;
  logic [15:0]       pend_addr;
  logic signed [7:0] pend_rssi;
  logic [7:0]        pend_lqi;
  logic [31:0]       pend_silent;
  logic [15:0]       cand_addr;
  logic signed [7:0] cand_rssi;
  logic [7:0]        cand_lqi;

  // RAM and divider hookup
  logic             ram_we;
  logic [IDX_W-1:0] ram_addr;
  entry_t           ram_wdata;
  entry_t           rdata;
  logic             div_start;
  logic [63:0]      div_in;
  logic             div_done;
  logic [63:0]      div_q;

  src_t        src;
  logic        accept;
  logic [63:0] gap;
  logic        eligible;
  logic        hit;
  logic [7:0]  count_next;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign src    = parse_src(header_low, header_mid, header_top, frame_len);
  assign gap    = now - rdata.seen;
  assign eligible = rdata.used && !rdata.down && (rdata.count >= frames_needed) &&
                    (gap >= {28'd0, limit});
  assign hit    = rdata.used && (rdata.addr == src_addr);
  assign count_next = (old_count == 8'hFF) ? old_count : old_count + 8'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx;
    ram_wdata = '0;
    div_start = 1'b0;
    div_in    = now_us;
    unique case (state)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE:  div_start = accept && (req_type || src.ok);
      ST_CHECK: begin
        if (is_tick && eligible) begin
          ram_we         = 1'b1;
          ram_wdata      = rdata;
          ram_wdata.down = 1'b1;
          div_start      = 1'b1;
          div_in         = gap;
        end
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        ram_addr  = slot_sel;
        ram_wdata = '{used: 1'b1, down: 1'b0, count: count_next, addr: src_addr,
                      seen: now, rssi: rssi, lqi: lqi};
      end
      default: ;
    endcase
  end

  dsm_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(DEVICE_SLOTS)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(rdata)
  );

  dsm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_in),
    .done    (div_done),
    .quotient(div_q)
  );

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold     <= THRESH_RESET;
      frames_needed <= FRAMES_NEEDED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRESHOLD:     if (cfg_data >= THRESH_MIN) threshold <= cfg_data;
        CFG_FRAMES_NEEDED: frames_needed <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sequencer and event outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      idx         <= '0;
      pend_valid  <= 1'b0;
      event_valid <= 1'b0;
    end else begin
      event_valid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept && (req_type || src.ok)) begin
            is_tick     <= req_type;
            now         <= now_us;
            src_addr    <= src.addr;
            rssi        <= frame_rssi;
            lqi         <= frame_lqi;
            chan        <= channel;
            limit       <= {20'd0, threshold} * {16'd0, US_PER_S};
            idx         <= '0;
            spare_found <= 1'b0;
            ev_count    <= '0;
            pend_valid  <= 1'b0;
            state       <= ST_STAMP;
          end
        end
        ST_STAMP: begin
          if (div_done) begin
            stamp <= div_q[44:0];
            state <= ST_READ;
          end
        end
        ST_READ: state <= ST_CHECK;
        ST_CHECK: begin
          if (is_tick) begin
            if (eligible) begin
              cand_addr <= rdata.addr;
              cand_rssi <= rdata.rssi;
              cand_lqi  <= rdata.lqi;
              state     <= ST_GAPDIV;
            end else if (idx == LAST_IDX) begin
              state <= ST_FLUSH;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end else if (hit) begin
            slot_sel  <= idx;
            old_down  <= rdata.down;
            old_count <= rdata.count;
            state     <= ST_UPDATE;
          end else begin
            if (!rdata.used && !spare_found) begin
              spare_found <= 1'b1;
              spare_idx   <= idx;
            end
            if (idx == LAST_IDX) begin
              // a never-used slot holds down clear and count zero
              old_down  <= 1'b0;
              old_count <= '0;
              slot_sel  <= spare_found ? spare_idx : idx;
              state     <= (spare_found || !rdata.used) ? ST_UPDATE : ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_UPDATE: begin
          if (old_down) begin
            event_valid    <= 1'b1;
            event_kind     <= KIND_RECOVER;
            device_addr    <= src_addr;
            last_rssi      <= rssi;
            last_lqi       <= lqi;
            event_channel  <= '0;
            stamp_seconds  <= stamp;
            silent_seconds <= '0;
            last_of_run    <= 1'b1;
          end
          state <= ST_IDLE;
        end
        ST_GAPDIV: begin
          if (div_done) begin
            // hold each event until the next one shows up, so the final
            // one can carry last_of_run
            if (pend_valid) begin
              event_valid    <= 1'b1;
              event_kind     <= KIND_SILENT;
              device_addr    <= pend_addr;
              last_rssi      <= pend_rssi;
              last_lqi       <= pend_lqi;
              event_channel  <= chan;
              stamp_seconds  <= stamp;
              silent_seconds <= pend_silent;
              last_of_run    <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_addr   <= cand_addr;
            pend_rssi   <= cand_rssi;
            pend_lqi    <= cand_lqi;
            pend_silent <= div_q[31:0];
            ev_count    <= ev_count + 1'b1;
            if ((ev_count + 1'b1 == CAP_W'(RESULT_CAP)) || (idx == LAST_IDX)) begin
              state <= ST_FLUSH;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            event_valid    <= 1'b1;
            event_kind     <= KIND_SILENT;
            device_addr    <= pend_addr;
            last_rssi      <= pend_rssi;
            last_lqi       <= pend_lqi;
            event_channel  <= chan;
            stamp_seconds  <= stamp;
            silent_seconds <= pend_silent;
            last_of_run    <= 1'b1;
          end
          pend_valid <= 1'b0;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // events only come out of item work
  a_event_after_busy: assert property (@(posedge clk) disable iff (rst)
    event_valid |-> $past(busy))
    else $error("event issued with no transaction in progress");

  // slot table is never written while idle
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ram_we)
    else $error("slot write while idle");

  // recovery events are single and carry no channel or silence length
  a_recover_shape: assert property (@(posedge clk) disable iff (rst)
    (event_valid && event_kind == KIND_RECOVER) |->
      (last_of_run && event_channel == 8'd0 && silent_seconds == 32'd0))
    else $error("malformed recovery event");

endmodule
